// ----- hw/rtl/tpdf_pkg.sv -----
// Package for the temporal pixel denoise filter: payload types and filter constants.
// Used by the channel interfaces and the top level; depends on nothing.
package tpdf_pkg;

  // Pixel item as it enters the block.
  typedef struct packed {
    logic [7:0] averaged_pixel;
    logic [7:0] source_pixel;
    logic       last_in_block;
  } pix_in_t;

  // Result item as it leaves the block.
  typedef struct packed {
    logic [7:0]        filtered_pixel;
    logic signed [15:0] adjust_total;
    logic              block_done;
  } res_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic strong_mode;
  } cfg_t;

  // Differences up to this limit pass the averaged pixel through.
  localparam logic [7:0] PassLimit       = 8'd3;
  localparam logic [7:0] PassLimitStrong = 8'd4;

  // Upper ends of the small and medium difference bands.
  localparam logic [7:0] SmallDiffMax = 8'd7;
  localparam logic [7:0] MidDiffMax   = 8'd15;

  // Step sizes toward the average for each band.
  localparam logic [3:0] StepSmall = 4'd3;
  localparam logic [3:0] StepMid   = 4'd4;
  localparam logic [3:0] StepLarge = 4'd6;

  localparam logic [8:0] PixelMax = 9'd255;

  // The block total saturates at six times the longest block.
  localparam int MaxBlockPixels = 4096;
  localparam int TotalLimit     = StepLarge * MaxBlockPixels;

endpackage

// ----- hw/rtl/tpdf_if.sv -----
// Valid/ready channel interfaces for the temporal pixel denoise filter.
// Depends on tpdf_pkg for the payload types.
interface tpdf_pix_if;
  logic              valid;
  logic              ready;
  tpdf_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpdf_res_if;
  logic               valid;
  logic               ready;
  tpdf_pkg::res_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpdf_cfg_if;
  logic           valid;
  logic           ready;
  tpdf_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/temporal_pixel_denoise_filter_unit.sv -----
// Top level of the temporal pixel denoise filter: input register, per-pixel filter
// and block total, result register. Depends on tpdf_pkg and the interfaces in tpdf_if.sv.
//
// Usage:
// Pixels of a block arrive on pix_in_i, one per transfer, in raster order, each
// with its motion-compensated average, its source value and a last-of-block mark.
// Every pixel yields exactly one result on res_out_o: the filtered pixel, the
// block's running adjustment total including that pixel, and a done flag that
// copies the last mark. The total is cleared after the last pixel of a block.
// The strong_mode register is written through cfg_i, which is always ready; a
// write is meant to happen between blocks and applies to the next pixel filtered.
//
// Timing: an accepted pixel is held in the input register, filtered from it
// combinationally and moved into the result register that drives res_out_o. One
// pixel is accepted per cycle while res_out_o is ready; the rate is set by the
// single filter stage, whose only loop is the update of the block total.
//
// Stalls: when the receiver holds ready low the result register keeps its item,
// the input register fills and then pix_in_i ready drops; nothing is lost.
// Reset clears both valid flags, the block total and strong_mode.
module temporal_pixel_denoise_filter_unit (
  input logic        clk_i,
  input logic        rst_ni,
  tpdf_pix_if.sink   pix_in_i,
  tpdf_cfg_if.sink   cfg_i,
  tpdf_res_if.source res_out_o
);

  // Input register stage.
  logic              s1_valid_q;
  tpdf_pkg::pix_in_t s1_q;

  // Result register stage.
  logic               out_valid_q;
  tpdf_pkg::res_out_t out_q;
  tpdf_pkg::res_out_t res_d;

  logic signed [15:0] total_q;
  logic signed [15:0] total_d;
  logic               strong_q;

  logic out_adv;
  logic s1_adv;
  logic in_ready;

  // Filter datapath signals.
  logic signed [8:0]  diff;
  logic [7:0]         abs_diff;
  logic [7:0]         pass_lim;
  logic [3:0]         step;
  logic [8:0]         pix_up;
  logic [8:0]         pix_dn;
  logic [7:0]         pix;
  logic signed [4:0]  change;
  logic signed [16:0] sum;
  logic signed [16:0] lim_pos;
  logic signed [16:0] lim_neg;

  // The result register takes a new item when it is empty or being drained.
  assign out_adv  = !out_valid_q || res_out_o.ready;
  assign s1_adv   = s1_valid_q && out_adv;
  assign in_ready = !s1_valid_q || out_adv;

  assign pix_in_i.ready  = in_ready;
  assign cfg_i.ready     = 1'b1;
  assign res_out_o.valid = out_valid_q;
  assign res_out_o.data  = out_q;

  assign lim_pos = 17'(tpdf_pkg::TotalLimit);
  assign lim_neg = -lim_pos;

  // Per-pixel filter: pass the average through for small differences, otherwise
  // step the source toward the average by an amount picked from the difference band.
  always_comb begin
    diff     = $signed({1'b0, s1_q.averaged_pixel}) - $signed({1'b0, s1_q.source_pixel});
    abs_diff = diff[8] ? 8'(-diff) : diff[7:0];
    pass_lim = strong_q ? tpdf_pkg::PassLimitStrong : tpdf_pkg::PassLimit;

    if (abs_diff <= tpdf_pkg::SmallDiffMax) begin
      step = tpdf_pkg::StepSmall;
    end else if (abs_diff <= tpdf_pkg::MidDiffMax) begin
      step = tpdf_pkg::StepMid;
    end else begin
      step = tpdf_pkg::StepLarge;
    end

    pix_up = {1'b0, s1_q.source_pixel} + {5'd0, step};
    pix_dn = {1'b0, s1_q.source_pixel} - {5'd0, step};

    if (abs_diff <= pass_lim) begin
      pix    = s1_q.averaged_pixel;
      change = 5'(diff);
    end else if (!diff[8]) begin
      pix    = (pix_up > tpdf_pkg::PixelMax) ? tpdf_pkg::PixelMax[7:0] : pix_up[7:0];
      change = $signed({1'b0, step});
    end else begin
      // A borrow out of the subtraction means the result went below zero.
      pix    = pix_dn[8] ? 8'd0 : pix_dn[7:0];
      change = -$signed({1'b0, step});
    end

    // Add to the block total and saturate at the total limit.
    sum = 17'(total_q) + 17'(change);
    if (sum > lim_pos) begin
      total_d = 16'(lim_pos);
    end else if (sum < lim_neg) begin
      total_d = 16'(lim_neg);
    end else begin
      total_d = sum[15:0];
    end

    res_d.filtered_pixel = pix;
    res_d.adjust_total   = total_d;
    res_d.block_done     = s1_q.last_in_block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      strong_q    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= pix_in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        total_q <= s1_q.last_in_block ? '0 : total_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        strong_q <= cfg_i.data.strong_mode;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (pix_in_i.valid && in_ready) begin
      s1_q <= pix_in_i.data;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  // The block total never leaves its saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (17'(total_q) <= lim_pos) && (17'(total_q) >= lim_neg))
    else $error("block total outside saturation range");

  // The total starts from zero after the last pixel of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.last_in_block |=> total_q == '0)
    else $error("block total not cleared after last pixel");

  // Within a block the total moves by at most the largest step per pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_q.last_in_block |=>
      ((17'(total_q) - 17'($past(total_q))) <= 17'sd6) &&
      ((17'(total_q) - 17'($past(total_q))) >= -17'sd6))
    else $error("block total changed by more than one step");

  // The total changes only when a pixel moves into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(total_q))
    else $error("block total changed without a filtered pixel");

endmodule
